### rtl/core/lcd_mode_timing_sequencer_assert.svh
// Assertion macros for the checker of the LCD mode timing sequencer.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef LCD_MODE_TIMING_SEQUENCER_ASSERT_SVH
`define LCD_MODE_TIMING_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define LMTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lcdmts check failed");

// Next-cycle implication.
`define LMTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("lcdmts check failed");

`endif

### rtl/core/lcdmts_pkg.sv
// ----------------------------------------------------------------------------
// lcdmts_pkg
// Types, timing constants and register codes of the LCD mode timing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdmts_pkg;

    localparam int MAX_DOTS_PER_ITEM = 255;
    localparam int VISIBLE_LINES     = 144;
    localparam int MAX_EVENTS        = 5;

    localparam logic [9:0] DOT_MAX_PER_ITEM = 10'(MAX_DOTS_PER_ITEM);
    localparam logic [9:0] DOT_SAT          = 10'd1023;
    localparam logic [9:0] LEN_OAM          = 10'd80;
    localparam logic [9:0] LEN_DRAW         = 10'd172;
    localparam logic [9:0] LEN_HBLANK       = 10'd204;
    localparam logic [9:0] LEN_LINE         = 10'd456;
    localparam logic [7:0] LINE_VISIBLE     = 8'(VISIBLE_LINES);
    localparam logic [7:0] LINE_LAST        = 8'd153;

    // STAT interrupt enable bit positions
    localparam int IRQ_EN_HBLANK  = 0;
    localparam int IRQ_EN_VBLANK  = 1;
    localparam int IRQ_EN_OAM     = 2;
    localparam int IRQ_EN_COMPARE = 3;

    typedef logic [7:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LCD_ENABLE   = 8'd0;
    localparam t_cfg_idx CFG_STAT_IRQ_EN  = 8'd1;
    localparam t_cfg_idx CFG_COMPARE_LINE = 8'd2;
    localparam t_cfg_idx CFG_SKIP_RENDER  = 8'd3;

    typedef logic [2:0] t_evt_cnt;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_lcd_mode;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_ctrl_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take the input transaction
        logic step;     // cross one period boundary and load its event
        logic status;   // load the closing status item
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic can_step;  // display on and a full period is in the counter
        logic slot_free; // output register empty or being taken
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/lcdmts_ctrl.sv
// ----------------------------------------------------------------------------
// lcdmts_ctrl
// Sequencer control: accepts one item, issues up to five steps, then status.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdmts_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  lcdmts_pkg::t_dp_sts i_sts,
    output lcdmts_pkg::t_dp_cmd o_cmd
);
    import lcdmts_pkg::*;

    t_ctrl_state r_state, n_state;
    t_evt_cnt    r_evt_cnt, n_evt_cnt;
    logic        do_step;

    assign do_step = i_sts.can_step && (r_evt_cnt < t_evt_cnt'(MAX_EVENTS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RUN;
            S_RUN:  if (i_sts.slot_free && !do_step) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        n_evt_cnt  = r_evt_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_evt_cnt    = '0;
                end
            end
            S_RUN: begin
                if (i_sts.slot_free) begin
                    if (do_step) begin
                        o_cmd.step = 1'b1;
                        n_evt_cnt  = r_evt_cnt + 3'd1;
                    end else begin
                        o_cmd.status = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_evt_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_evt_cnt <= n_evt_cnt;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lcdmts_dp.sv
// ----------------------------------------------------------------------------
// lcdmts_dp
// Timing datapath: config registers, dot counter, line and mode state, the
// one-boundary step unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdmts_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  lcdmts_pkg::t_cfg_idx i_cfg_index,
    input  wire  [7:0]           i_cfg_data,
    input  wire  [7:0]           i_dots,
    input  lcdmts_pkg::t_dp_cmd  i_cmd,
    output lcdmts_pkg::t_dp_sts  o_sts,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [7:0]           o_line,
    output logic [1:0]           o_lcd_mode,
    output logic                 o_coincidence,
    output logic                 o_render_request,
    output logic                 o_vblank_irq,
    output logic                 o_stat_irq,
    output logic                 o_frame_ready,
    output logic                 o_last
);
    import lcdmts_pkg::*;

    // config
    logic       r_lcd_en;
    logic [3:0] r_irq_en;
    logic [7:0] r_cmp_line;
    logic       r_skip;

    // timing state
    logic [9:0] r_dc;
    logic [7:0] r_line;
    t_lcd_mode  r_mode;
    logic       r_coinc;

    // output register
    logic       r_out_valid;
    logic [7:0] r_o_line;
    logic [1:0] r_o_mode;
    logic       r_o_coinc, r_o_rr, r_o_vb, r_o_st, r_o_fr, r_o_last;

    // step unit
    logic [9:0]  len;
    logic [9:0]  s_dc;
    logic [7:0]  s_line, line_inc;
    t_lcd_mode   s_mode;
    logic        s_coinc, s_rr, s_vb, s_st, s_fr;
    logic [9:0]  dots_sat;
    logic [10:0] dot_sum;

    assign dots_sat = ({2'b0, i_dots} > DOT_MAX_PER_ITEM) ? DOT_MAX_PER_ITEM : {2'b0, i_dots};
    assign dot_sum  = {1'b0, r_dc} + {1'b0, dots_sat};
    assign line_inc = r_line + 8'd1;

    always_comb begin
        unique case (r_mode)
            MODE_OAM:    len = LEN_OAM;
            MODE_DRAW:   len = LEN_DRAW;
            MODE_HBLANK: len = LEN_HBLANK;
            MODE_VBLANK: len = LEN_LINE;
            default:     len = LEN_LINE;
        endcase
    end

    always_comb begin
        s_dc    = r_dc - len;
        s_line  = r_line;
        s_mode  = r_mode;
        s_coinc = r_coinc;
        s_rr    = 1'b0;
        s_vb    = 1'b0;
        s_st    = 1'b0;
        s_fr    = 1'b0;
        unique case (r_mode)
            MODE_OAM: s_mode = MODE_DRAW;
            MODE_DRAW: begin
                s_mode = MODE_HBLANK;
                s_rr   = !r_skip && (r_line < LINE_VISIBLE);
                s_st   = r_irq_en[IRQ_EN_HBLANK];
            end
            MODE_HBLANK: begin
                s_line  = line_inc;
                s_coinc = (line_inc == r_cmp_line);
                if (line_inc == LINE_VISIBLE) begin
                    s_mode = MODE_VBLANK;
                    s_fr   = !r_skip;
                    s_vb   = 1'b1;
                    s_st   = r_irq_en[IRQ_EN_VBLANK];
                end else begin
                    s_mode = MODE_OAM;
                    s_st   = r_irq_en[IRQ_EN_OAM];
                end
                s_st = s_st || (s_coinc && r_irq_en[IRQ_EN_COMPARE]);
            end
            MODE_VBLANK: begin
                if (line_inc > LINE_LAST) begin
                    // wrap to the top of the next frame
                    s_line  = '0;
                    s_mode  = MODE_OAM;
                    s_coinc = (r_cmp_line == 8'd0);
                    s_st    = r_irq_en[IRQ_EN_OAM];
                end else begin
                    s_line  = line_inc;
                    s_coinc = (line_inc == r_cmp_line);
                end
                s_st = s_st || (s_coinc && r_irq_en[IRQ_EN_COMPARE]);
            end
            default: ;
        endcase
    end

    assign o_sts.can_step  = r_lcd_en && (r_dc >= len);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcd_en   <= 1'b1;
            r_irq_en   <= '0;
            r_cmp_line <= '0;
            r_skip     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LCD_ENABLE:   r_lcd_en   <= i_cfg_data[0];
                CFG_STAT_IRQ_EN:  r_irq_en   <= i_cfg_data[3:0];
                CFG_COMPARE_LINE: r_cmp_line <= i_cfg_data;
                CFG_SKIP_RENDER:  r_skip     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc    <= '0;
            r_line  <= '0;
            r_mode  <= MODE_OAM;
            r_coinc <= 1'b0;
        end else if (i_cmd.accept) begin
            if (!r_lcd_en) begin
                // display off: drop the dots, hold the counter
                r_line  <= '0;
                r_mode  <= MODE_HBLANK;
                r_coinc <= 1'b0;
            end else begin
                r_dc <= dot_sum[10] ? DOT_SAT : dot_sum[9:0];
            end
        end else if (i_cmd.step) begin
            r_dc    <= s_dc;
            r_line  <= s_line;
            r_mode  <= s_mode;
            r_coinc <= s_coinc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step || i_cmd.status) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_o_line  <= s_line;
            r_o_mode  <= s_mode;
            r_o_coinc <= s_coinc;
            r_o_rr    <= s_rr;
            r_o_vb    <= s_vb;
            r_o_st    <= s_st;
            r_o_fr    <= s_fr;
            r_o_last  <= 1'b0;
        end else if (i_cmd.status) begin
            r_o_line  <= r_line;
            r_o_mode  <= r_mode;
            r_o_coinc <= r_coinc;
            r_o_rr    <= 1'b0;
            r_o_vb    <= 1'b0;
            r_o_st    <= 1'b0;
            r_o_fr    <= 1'b0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_line           = r_o_line;
    assign o_lcd_mode       = r_o_mode;
    assign o_coincidence    = r_o_coinc;
    assign o_render_request = r_o_rr;
    assign o_vblank_irq     = r_o_vb;
    assign o_stat_irq       = r_o_st;
    assign o_frame_ready    = r_o_fr;
    assign o_last           = r_o_last;

endmodule

`default_nettype wire

### rtl/core/lcd_mode_timing_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer
// LCD mode timing: turns elapsed dot counts into mode change events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_dots): each transaction
//   adds that many dot clocks to the dot counter (saturating at 1023).
//   Output channel (o_out_valid / i_out_ready): for each period boundary the
//   counter covers, one event transaction goes out (at most five per input),
//   then one closing status transaction with o_last high.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 lcd
//   enable, 1 STAT irq enables, 2 compare line, 3 skip render. Write only
//   while the sequencer is idle; other indexes are ignored.
// Timing:
//   An input transaction is taken into the dot counter, then one output
//   transaction is loaded per cycle by the single step unit while the output
//   register is free (a held output register stalls the steps); a new input
//   is taken only after the closing status of the item has been loaded.
// Reset: line 0, OAM scan, counter 0, display enabled, no output pending.
// Stall: a held output register blocks further steps; the state waits intact.
// Display off: only a status item is produced, showing line 0 and hblank.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_timing_sequencer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // config channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  lcdmts_pkg::t_cfg_idx i_cfg_index,
    input  wire  [7:0]           i_cfg_data,
    // input channel
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire  [7:0]           i_dots,
    // output channel
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [7:0]           o_line,
    output logic [1:0]           o_lcd_mode,
    output logic                 o_coincidence,
    output logic                 o_render_request,
    output logic                 o_vblank_irq,
    output logic                 o_stat_irq,
    output logic                 o_frame_ready,
    output logic                 o_last
);
    import lcdmts_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // registers take writes at any time; callers keep to idle periods
    assign o_cfg_ready = 1'b1;

    // sequence accept, steps and the closing status
    lcdmts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // hold the timing state and compute one boundary per step
    lcdmts_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_dots           (i_dots),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_line           (o_line),
        .o_lcd_mode       (o_lcd_mode),
        .o_coincidence    (o_coincidence),
        .o_render_request (o_render_request),
        .o_vblank_irq     (o_vblank_irq),
        .o_stat_irq       (o_stat_irq),
        .o_frame_ready    (o_frame_ready),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

### rtl/core/lcdmts_check.sv
// ----------------------------------------------------------------------------
// lcdmts_check
// Port-level checks of the LCD mode timing sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_mode_timing_sequencer_assert.svh"

module lcdmts_check (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire  [7:0]           o_line,
    input wire  [1:0]           o_lcd_mode,
    input wire                  o_render_request,
    input wire                  o_last
);
    import lcdmts_pkg::*;

    // while idle, only a closing status item may still wait
    `LMTS_ASSERT_NOW(a_idle_only_status, o_in_ready && o_out_valid, o_last)

    // one item at a time
    `LMTS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // render requests come only on the entry to hblank
    `LMTS_ASSERT_NOW(a_render_in_hblank, o_out_valid && o_render_request,
                     !o_last && (o_lcd_mode == MODE_HBLANK))

    // lines never pass the last vblank line
    `LMTS_ASSERT_NOW(a_line_range, o_out_valid, o_line <= LINE_LAST)

    // a stalled result holds
    `LMTS_ASSERT_NEXT(a_stall_hold, o_out_valid && !i_out_ready,
                      o_out_valid && $stable(o_line) && $stable(o_last))

endmodule

bind lcd_mode_timing_sequencer lcdmts_check u_check (.*);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LCD mode timing sequencer: drives dot counts and
// register writes, predicts every mode event and status transaction, and
// checks the output channel field by field under random stalls on both sides.
// ----------------------------------------------------------------------------

module testbench;

    import lcdmts_pkg::*;

    // Mode period lengths and frame geometry, kept local to the bench
    localparam logic [9:0] DOTS_OAM_SCAN   = 10'd80;
    localparam logic [9:0] DOTS_DRAWING    = 10'd172;
    localparam logic [9:0] DOTS_HBLANK     = 10'd204;
    localparam logic [9:0] DOTS_LINE       = 10'd456;
    localparam logic [9:0] DOT_CEILING     = 10'd1023;
    localparam logic [7:0] FIRST_VBL_LINE  = 8'd144;
    localparam logic [7:0] FINAL_LINE      = 8'd153;
    localparam int         EVENTS_PER_ITEM = 5;

    localparam int RAND_PHASES     = 10;
    localparam int PHASE_ITEMS     = 30;
    localparam int HOLDOFF_AT      = 120;
    localparam int HOLDOFF_CYCLES  = 250;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 16;

    typedef enum logic { REQ_DOTS, REQ_REG } t_req_kind;

    typedef struct {
        t_req_kind  kind;
        logic [7:0] dots;
        t_cfg_idx   idx;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        logic [7:0] line_no;
        logic [1:0] mode;
        logic       coin;
        logic       render;
        logic       vblank;
        logic       stat;
        logic       frame;
        logic       fin;
    } t_mode_evt;

    // ------------------------------------------------------------------------
    // DUT ports, inputs known from time zero
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index = CFG_LCD_ENABLE;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_dots      = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_line;
    logic [1:0] o_lcd_mode;
    logic       o_coincidence;
    logic       o_render_request;
    logic       o_vblank_irq;
    logic       o_stat_irq;
    logic       o_frame_ready;
    logic       o_last;

    lcd_mode_timing_sequencer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_dots           (i_dots),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_line           (o_line),
        .o_lcd_mode       (o_lcd_mode),
        .o_coincidence    (o_coincidence),
        .o_render_request (o_render_request),
        .o_vblank_irq     (o_vblank_irq),
        .o_stat_irq       (o_stat_irq),
        .o_frame_ready    (o_frame_ready),
        .o_last           (o_last)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_req      pending[$];     // transactions waiting to be offered
    t_mode_evt events_due[$];  // predicted output transactions, oldest first

    int fail_count    = 0;
    int items_taken   = 0;
    int send_idle_pct = 0;     // chance of a sender gap after each transaction
    int recv_idle_pct = 0;     // chance per cycle of a receiver stall burst
    bit quiet_tail    = 1'b0;  // final stretch: no idling on either side

    // Shadow registers, at their reset values
    logic       lcd_on   = 1'b1;
    logic [3:0] irq_en   = 4'd0;
    logic [7:0] cmp_line = 8'd0;
    logic       skip_rnd = 1'b0;

    // Shadow timing state, at its reset values
    logic [9:0] dot_cnt  = 10'd0;
    logic [7:0] line_now = 8'd0;
    t_lcd_mode  mode_now = MODE_OAM;
    logic       coin_now = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Recompute the coincidence flag after a line change; report a compare irq.
    function automatic logic relatch_compare();
        coin_now = (line_now == cmp_line);
        return coin_now && irq_en[IRQ_EN_COMPARE];
    endfunction

    task automatic post_event(input logic rr, input logic vb, input logic st,
                              input logic fr, input logic fin);
        t_mode_evt ev;
        ev.line_no = line_now;
        ev.mode    = mode_now;
        ev.coin    = coin_now;
        ev.render  = rr;
        ev.vblank  = vb;
        ev.stat    = st;
        ev.frame   = fr;
        ev.fin     = fin;
        events_due.push_back(ev);
    endtask

    // Advance the shadow timing by one dot count and queue every event it
    // causes, then the closing status transaction.
    task automatic predict_mode_events(input logic [7:0] dots);
        logic [10:0] sum;
        logic [9:0]  span;
        logic        rr, vb, st, fr;
        logic        stepping;
        int          n;
        if (!lcd_on) begin
            // Display off: force line and mode low, hold the counter, drop dots
            line_now = 8'd0;
            mode_now = MODE_HBLANK;
            coin_now = 1'b0;
        end else begin
            sum = {1'b0, dot_cnt} + {3'b0, dots};
            dot_cnt = (sum > {1'b0, DOT_CEILING}) ? DOT_CEILING : sum[9:0];
            n = 0;
            stepping = 1'b1;
            while (stepping && n < EVENTS_PER_ITEM) begin
                case (mode_now)
                    MODE_OAM:    span = DOTS_OAM_SCAN;
                    MODE_DRAW:   span = DOTS_DRAWING;
                    MODE_HBLANK: span = DOTS_HBLANK;
                    default:     span = DOTS_LINE;
                endcase
                if (dot_cnt < span) begin
                    stepping = 1'b0;
                end else begin
                    dot_cnt = dot_cnt - span;
                    rr = 1'b0;
                    vb = 1'b0;
                    st = 1'b0;
                    fr = 1'b0;
                    case (mode_now)
                        MODE_OAM: begin
                            mode_now = MODE_DRAW;
                        end
                        MODE_DRAW: begin
                            rr = !skip_rnd && (line_now < FIRST_VBL_LINE);
                            mode_now = MODE_HBLANK;
                            st = irq_en[IRQ_EN_HBLANK];
                        end
                        MODE_HBLANK: begin
                            line_now = line_now + 8'd1;
                            st = relatch_compare();
                            if (line_now == FIRST_VBL_LINE) begin
                                mode_now = MODE_VBLANK;
                                fr = !skip_rnd;
                                vb = 1'b1;
                                st = st | irq_en[IRQ_EN_VBLANK];
                            end else begin
                                mode_now = MODE_OAM;
                                st = st | irq_en[IRQ_EN_OAM];
                            end
                        end
                        default: begin
                            // Vertical blank: step lines, wrap to the top after the last
                            line_now = line_now + 8'd1;
                            if (line_now > FINAL_LINE) begin
                                line_now = 8'd0;
                                mode_now = MODE_OAM;
                                st = relatch_compare();
                                st = st | irq_en[IRQ_EN_OAM];
                            end else begin
                                st = relatch_compare();
                            end
                        end
                    endcase
                    post_event(rr, vb, st, fr, 1'b0);
                    n++;
                end
            end
        end
        post_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic apply_reg_write(input t_cfg_idx idx, input logic [7:0] data);
        case (idx)
            CFG_LCD_ENABLE:   lcd_on   = data[0];
            CFG_STAT_IRQ_EN:  irq_en   = data[3:0];
            CFG_COMPARE_LINE: cmp_line = data;
            CFG_SKIP_RENDER:  skip_rnd = data[0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer dot counts and register writes from the pending queue
    // ------------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge i_clk) begin : driver
        logic send_v;
        logic cfg_v;
        send_v = i_in_valid;
        cfg_v  = i_cfg_valid;
        if (!i_rst_n) begin
            send_v = 1'b0;
            cfg_v  = 1'b0;
        end else begin
            // Retire transactions that completed at this edge
            if (i_in_valid && o_in_ready) begin
                predict_mode_events(i_dots);
                items_taken++;
                send_v = 1'b0;
                if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, 12);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
                cfg_v = 1'b0;
            end
            // Load the next transaction once the channel is free
            if (!send_v && !cfg_v) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (pending.size() != 0) begin
                    if (pending[0].kind == REQ_DOTS) begin
                        i_dots <= pending[0].dots;
                        send_v = 1'b1;
                        void'(pending.pop_front());
                    end else if (events_due.size() == 0) begin
                        // Write registers only once the sequencer has drained
                        i_cfg_index <= pending[0].idx;
                        i_cfg_data  <= pending[0].data;
                        cfg_v = 1'b1;
                        void'(pending.pop_front());
                    end
                end
            end
        end
        i_in_valid  <= send_v;
        i_cfg_valid <= cfg_v;
    end

    // ------------------------------------------------------------------------
    // Monitor: check each output transaction and drive backpressure
    // ------------------------------------------------------------------------
    int  stall_left   = 0;
    int  holdoff_left = 0;
    bit  holdoff_done = 1'b0;

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_mode_evt want;
        logic      rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (events_due.size() == 0) begin
                    $display({"%0t: unexpected transaction, expected none, ",
                              "actual line %0d mode %0d last %0d"},
                             $time, o_line, o_lcd_mode, o_last);
                    fail_count++;
                end else begin
                    want = events_due.pop_front();
                    compare_field("line",           want.line_no, o_line);
                    compare_field("lcd_mode",       want.mode,    o_lcd_mode);
                    compare_field("coincidence",    want.coin,    o_coincidence);
                    compare_field("render_request", want.render,  o_render_request);
                    compare_field("vblank_irq",     want.vblank,  o_vblank_irq);
                    compare_field("stat_irq",       want.stat,    o_stat_irq);
                    compare_field("frame_ready",    want.frame,   o_frame_ready);
                    compare_field("last",           want.fin,     o_last);
                end
            end
            // One long hold-off lets the sequencer fill up and stall its input
            if (holdoff_left != 0) begin
                holdoff_left--;
            end else if (!holdoff_done && items_taken >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES - 1;
            end else if (stall_left != 0) begin
                stall_left--;
            end else if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct) begin
                stall_left = $urandom_range(0, 11);
            end else begin
                rdy = 1'b1;
            end
        end
        i_out_ready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no channel moves for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
                || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[lcd_mode_timing_sequencer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_dots(input logic [7:0] dots);
        t_req r;
        r.kind = REQ_DOTS;
        r.dots = dots;
        r.idx  = CFG_LCD_ENABLE;
        r.data = 8'd0;
        pending.push_back(r);
    endtask

    task automatic queue_reg_write(input t_cfg_idx idx, input logic [7:0] data);
        t_req r;
        r.kind = REQ_REG;
        r.dots = 8'd0;
        r.idx  = idx;
        r.data = data;
        pending.push_back(r);
    endtask

    initial begin : stimulus
        int ph;
        int k;
        int aim;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk each mode boundary exactly: zero dots, just short, just on
        queue_dots(8'd0);
        queue_dots(8'd79);
        queue_dots(8'd1);
        queue_dots(8'd171);
        queue_dots(8'd1);
        queue_dots(8'd203);
        queue_dots(8'd1);
        queue_dots(8'd255);
        queue_dots(8'd255);
        queue_dots(8'd255);

        // All STAT sources on, compare a line ahead, render suppressed
        queue_reg_write(CFG_STAT_IRQ_EN, 8'd15);
        queue_reg_write(CFG_COMPARE_LINE, 8'd3);
        queue_reg_write(CFG_SKIP_RENDER, 8'd1);
        repeat (4) queue_dots(8'd255);
        queue_dots(8'd170);

        // Display off: only status transactions, dots dropped
        queue_reg_write(CFG_LCD_ENABLE, 8'd0);
        queue_dots(8'd0);
        queue_dots(8'd255);
        queue_dots(8'd85);

        // Back on: continue from hblank of line 0 with the held counter
        queue_reg_write(CFG_LCD_ENABLE, 8'd1);
        queue_reg_write(CFG_SKIP_RENDER, 8'd0);
        queue_reg_write(CFG_COMPARE_LINE, 8'd0);
        queue_reg_write(CFG_STAT_IRQ_EN, 8'd1);
        queue_dots(8'd204);
        queue_dots(8'd255);
        queue_dots(8'd255);

        // Random phases: mostly full dot counts so the run covers a whole frame
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            while (pending.size() != 0) @(posedge i_clk);
            if (ph == RAND_PHASES - 1) begin
                quiet_tail    = 1'b1;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = 20 * $urandom_range(0, 2);
                recv_idle_pct = 6 * $urandom_range(0, 2);
            end
            // Aim the compare line a few lines ahead so coincidences happen
            aim = int'(line_now) + $urandom_range(0, 10);
            if (aim > FINAL_LINE) aim = $urandom_range(0, 4);
            if ($urandom_range(0, 5) == 0) aim = 255;
            queue_reg_write(CFG_COMPARE_LINE, 8'(aim));
            if (ph == 0)
                queue_reg_write(CFG_STAT_IRQ_EN, 8'd0);
            else if (ph == 1)
                queue_reg_write(CFG_STAT_IRQ_EN, 8'd15);
            else
                queue_reg_write(CFG_STAT_IRQ_EN, 8'($urandom_range(0, 15)));
            queue_reg_write(CFG_SKIP_RENDER, 8'($urandom_range(0, 1)));
            queue_reg_write(CFG_LCD_ENABLE, 8'd1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 85)
                    queue_dots(8'd255);
                else
                    queue_dots(8'($urandom_range(0, 255)));
            end
        end

        // Drain everything, then give stray transactions a chance to show up
        while (pending.size() != 0 || i_in_valid || i_cfg_valid || events_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && events_due.size() == 0) begin
            $display("[lcd_mode_timing_sequencer] OK");
        end else begin
            $display("[lcd_mode_timing_sequencer] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lcdmts_pkg.sv
rtl/core/lcdmts_ctrl.sv
rtl/core/lcdmts_dp.sv
rtl/core/lcd_mode_timing_sequencer.sv
rtl/core/lcdmts_check.sv
verif/testbench.sv
